// ----- rtl/serial_frame_receiver_core_defines.svh -----
// Assertion macros shared by the serial frame receiver RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfr_pkg.sv -----
// Types and constants of the serial frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int unsigned TICKS_W = 23;

    localparam logic [7:0]         HDR_FIRST       = 8'h07;
    localparam logic [7:0]         HDR_SECOND      = 8'h0E;
    localparam logic [7:0]         MIN_LENGTH      = 8'd5;
    localparam logic [7:0]         CMD_END_SESSION = 8'h52;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET   = 23'h500000;

    // result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_GOOD      = 3'd1;
    localparam logic [2:0] KIND_BAD_CSUM  = 3'd2;
    localparam logic [2:0] KIND_BAD_START = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CSUM    = 3'd5,
        PH_STOPPED = 3'd6
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] command;
        logic [7:0] frame_length;
        logic [7:0] index;
        logic [7:0] value;
        logic       ends_session;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_channels.sv -----
// Valid/ready channel interfaces for the serial frame receiver.
// Standalone; field widths follow sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic [7:0] index;
    logic [7:0] value;
    logic       ends_session;

    modport source (output valid, output kind, output command, output frame_length,
                    output index, output value, output ends_session, input ready);
    modport sink   (input valid, input kind, input command, input frame_length,
                    input index, input value, input ends_session, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfr_in_reg.sv -----
// Input register of the serial frame receiver: holds one accepted word.
// Depends on sfr_pkg and sfr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module sfr_in_reg
    import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfr_in_if.sink    in_ch,
    input  wire logic advance,
    output logic      item_valid,
    output item_t     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // refill in the same cycle the held word moves on
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{action: in_ch.action, rx_byte: in_ch.rx_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/sfr_parser.sv -----
// Frame parser of the serial frame receiver: phase, counters, checksum, timeout.
// Depends on sfr_pkg and the macros in serial_frame_receiver_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_frame_receiver_core_defines.svh"

module sfr_parser
    import sfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [TICKS_W-1:0] cfg_wr_data,
    input  wire logic               step,
    input  wire item_t              item,
    output logic                    has_result,
    output result_t                 result
);

    phase_t             phase_reg,         phase_next;
    logic [TICKS_W-1:0] idle_count_reg,    idle_count_next;
    logic [7:0]         length_seen_reg,   length_seen_next;
    logic [7:0]         running_sum_reg,   running_sum_next;
    logic [7:0]         payload_count_reg, payload_count_next;
    logic [7:0]         command_seen_reg,  command_seen_next;
    logic [TICKS_W-1:0] timeout_ticks_reg;

    logic [TICKS_W-1:0] idle_inc;
    logic [7:0]         sum_with_byte;
    logic [7:0]         count_inc;

    assign idle_inc      = idle_count_reg + 1'b1;
    assign sum_with_byte = running_sum_reg + item.rx_byte;
    assign count_inc     = payload_count_reg + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        idle_count_next    = idle_count_reg;
        length_seen_next   = length_seen_reg;
        running_sum_next   = running_sum_reg;
        payload_count_next = payload_count_reg;
        command_seen_next  = command_seen_reg;
        has_result         = 1'b0;
        result             = '0;

        if (phase_reg != PH_STOPPED)
        begin
            if (item.action)
            begin
                idle_count_next = idle_inc;
                if (idle_inc >= timeout_ticks_reg)
                begin
                    phase_next          = PH_STOPPED;
                    has_result          = 1'b1;
                    result.kind         = KIND_TIMEOUT;
                    result.ends_session = 1'b1;
                end
            end
            else
            begin
                idle_count_next = '0;
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        if (item.rx_byte == HDR_FIRST)
                        begin
                            phase_next = PH_HDR2;
                        end
                        else
                        begin
                            phase_next          = PH_STOPPED;
                            has_result          = 1'b1;
                            result.kind         = KIND_BAD_START;
                            result.ends_session = 1'b1;
                        end
                    end
                    PH_HDR2:
                    begin
                        phase_next = (item.rx_byte == HDR_SECOND) ? PH_LEN : PH_HDR1;
                    end
                    PH_LEN:
                    begin
                        if (item.rx_byte < MIN_LENGTH)
                        begin
                            phase_next = PH_HDR1;
                        end
                        else
                        begin
                            length_seen_next = item.rx_byte;
                            running_sum_next = item.rx_byte;
                            phase_next       = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        command_seen_next  = item.rx_byte;
                        running_sum_next   = sum_with_byte;
                        payload_count_next = '0;
                        phase_next         = PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        running_sum_next    = sum_with_byte;
                        payload_count_next  = count_inc;
                        has_result          = 1'b1;
                        result.kind         = KIND_PAYLOAD;
                        result.command      = command_seen_reg;
                        result.frame_length = length_seen_reg;
                        result.index        = payload_count_reg;
                        result.value        = item.rx_byte;
                        if (count_inc >= length_seen_reg - 8'd1)
                        begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM:
                    begin
                        has_result          = 1'b1;
                        result.command      = command_seen_reg;
                        result.frame_length = length_seen_reg;
                        if (sum_with_byte == 8'd0)
                        begin
                            result.kind = KIND_GOOD;
                            if (command_seen_reg == CMD_END_SESSION)
                            begin
                                result.ends_session = 1'b1;
                                phase_next          = PH_STOPPED;
                            end
                            else
                            begin
                                phase_next = PH_HDR1;
                            end
                        end
                        else
                        begin
                            result.kind = KIND_BAD_CSUM;
                            phase_next  = PH_HDR1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HDR1;
            idle_count_reg    <= '0;
            length_seen_reg   <= '0;
            running_sum_reg   <= '0;
            payload_count_reg <= '0;
            command_seen_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            idle_count_reg    <= idle_count_next;
            length_seen_reg   <= length_seen_next;
            running_sum_reg   <= running_sum_next;
            payload_count_reg <= payload_count_next;
            command_seen_reg  <= command_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_ticks_reg <= cfg_wr_data;
        end
    end

    `SFR_ASSERT_NEXT(a_stop_holds, phase_reg == PH_STOPPED,
                     phase_reg == PH_STOPPED, "left stopped phase")
    `SFR_ASSERT_NEXT(a_end_stops, step && has_result && result.ends_session,
                     phase_reg == PH_STOPPED, "session end did not stop parser")
    `SFR_ASSERT_NOW(a_len_ok, phase_reg == PH_PAYLOAD || phase_reg == PH_CSUM,
                    length_seen_reg >= MIN_LENGTH, "frame length below minimum")
    `SFR_ASSERT_NOW(a_count_ok, phase_reg == PH_PAYLOAD,
                    payload_count_reg < length_seen_reg - 8'd1, "payload index past frame")

endmodule

`default_nettype wire

// ----- rtl/sfr_out_reg.sv -----
// Result register of the serial frame receiver, drives the output channel.
// Depends on sfr_pkg and sfr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module sfr_out_reg
    import sfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    sfr_out_if.source    out_ch
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.kind         = result_reg.kind;
    assign out_ch.command      = result_reg.command;
    assign out_ch.frame_length = result_reg.frame_length;
    assign out_ch.index        = result_reg.index;
    assign out_ch.value        = result_reg.value;
    assign out_ch.ends_session = result_reg.ends_session;

endmodule

`default_nettype wire

// ----- rtl/serial_frame_receiver_core.sv -----
// Top level of the serial frame receiver: input register, parser, result register.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_in_reg, sfr_parser, sfr_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Serial frame receiver. Each input word is either a received byte (action 0)
// or one idle tick (action 1). The block hunts for the header 07 0E, then
// reads a length byte L (L below 5 drops back to hunting), a command byte,
// L-1 payload bytes and a checksum byte; every payload byte comes out as a
// kind 0 word with its index, and the frame end as kind 1 (good sum) or
// kind 2 (bad sum). A wrong first header byte (kind 3), timeout_ticks idle
// ticks in a row (kind 4) or a good frame with command 52h ends the session:
// the word carries ends_session and all later input is swallowed until reset.
// Throughput is one word per clock while out_ch keeps taking results: the parser
// state is a single phase register with 8-bit sum and count and a 23-bit idle
// counter, all updated as a word moves from the input to the result register.
// A word accepted on in_ch waits in the input register; its result is then
// loaded into the result register, which drives out_ch. While a result waits
// unread, the input register holds one more word and in_ch then stalls. The
// timeout register (cfg_wr_en/cfg_wr_data) resets to 500000h and may be
// written only while no word is in flight.
module serial_frame_receiver_core
    import sfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [TICKS_W-1:0] cfg_wr_data,
    sfr_in_if.sink                  in_ch,
    sfr_out_if.source               out_ch
);

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    has_result;
    result_t result;

    // advance the held word whenever the result slot is free or draining
    assign advance = item_valid && (!out_ch.valid || out_ch.ready);

    sfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (item),
        .has_result  (has_result),
        .result      (result)
    );

    // drop words that yield no result; load the rest
    sfr_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && has_result),
        .result (result),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
